// ----- rtl/psida_pkg.sv -----
package psida_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int ID_BITS    = 15;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int STEP_BITS  = $clog2(SLOT_COUNT + 2);

    // fixed field widths of the channels
    localparam int CMD_W  = 2;
    localparam int SLOT_W = 6;
    localparam int ID_W   = 15;

    localparam logic [ID_BITS-1:0] ID_MASK = {ID_BITS{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } psida_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot_index;
        logic [ID_W-1:0]   owner_id;
    } psida_req_t;

    typedef struct packed {
        logic              slot_found;
        logic [SLOT_W-1:0] free_slot;
        logic [ID_W-1:0]   chosen_id;
    } psida_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } psida_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // request transfer taken
        logic issue;     // read next table entry
        logic advance;   // candidate id is held: step it
        logic out_load;  // move result into output register
    } psida_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic hit;
        logic pass_done;
        logic stop;
        logic out_free;
    } psida_sts_t;

endpackage

// ----- rtl/psida_ctrl.sv -----
module psida_ctrl
    import psida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  psida_sts_t sts,
    output psida_ctl_t ctl
);

    psida_state_t state_reg;
    psida_state_t state_next;
    logic         accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.is_alloc ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if ((sts.hit && sts.stop) || sts.pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.load = accept;
            end
            ST_SCAN:
            begin
                ctl.issue   = !sts.hit;
                ctl.advance = sts.hit;
            end
            ST_DONE:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ----- rtl/psida_dp.sv -----
module psida_dp
    import psida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  psida_req_t req_data,
    input  psida_ctl_t ctl,
    output psida_sts_t sts,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output psida_rsp_t rsp_data
);

    logic [ID_BITS-1:0]    owner_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;

    logic [ID_BITS-1:0]    next_id_reg;
    logic [ID_BITS-1:0]    start_reg;
    logic [STEP_BITS-1:0]  steps_reg;
    logic [SLOT_BITS-1:0]  addr_reg;

    logic [ID_BITS-1:0]    rd_data_reg;
    logic                  pipe_vld_reg;
    logic                  pipe_slotv_reg;
    logic                  pipe_last_reg;

    logic                  free_found_reg;
    logic [SLOT_BITS-1:0]  free_slot_reg;

    logic                  out_vld_reg;
    psida_rsp_t            out_reg;

    logic                  idx_ok;
    logic [SLOT_BITS-1:0]  wr_idx;
    logic                  tbl_wr;
    logic [ID_BITS-1:0]    next_inc;
    logic                  at_bound;
    logic                  addr_last;

    assign idx_ok   = (int'(req_data.slot_index) < SLOT_COUNT);
    assign wr_idx   = req_data.slot_index[SLOT_BITS-1:0];
    assign tbl_wr   = ctl.load && idx_ok &&
                      (req_data.command == CMD_WRITE || req_data.command == CMD_CLEAR);
    assign next_inc = (next_id_reg == ID_MASK) ? ID_BITS'(1) : next_id_reg + ID_BITS'(1);
    assign at_bound = (steps_reg > STEP_BITS'(SLOT_COUNT));
    assign addr_last = (addr_reg == SLOT_BITS'(SLOT_COUNT - 1));

    assign sts.is_alloc  = (req_data.command == CMD_ALLOC);
    assign sts.hit       = pipe_vld_reg && pipe_slotv_reg && (rd_data_reg == next_id_reg);
    assign sts.pass_done = pipe_vld_reg && pipe_last_reg && !sts.hit;
    assign sts.stop      = at_bound || (next_inc == start_reg);
    assign sts.out_free  = !out_vld_reg || !rsp_stall;

    // owner table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            owner_mem[wr_idx] <= (req_data.command == CMD_WRITE) ?
                                 req_data.owner_id[ID_BITS-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            rd_data_reg <= owner_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (tbl_wr)
        begin
            valid_reg[wr_idx] <= (req_data.command == CMD_WRITE);
        end
    end

    // scan sequencing and id search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg    <= '0;
            start_reg      <= '0;
            steps_reg      <= '0;
            addr_reg       <= '0;
            pipe_vld_reg   <= 1'b0;
            pipe_slotv_reg <= 1'b0;
            pipe_last_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
        end
        else
        begin
            pipe_vld_reg <= ctl.issue;
            if (ctl.load)
            begin
                start_reg      <= next_id_reg;
                steps_reg      <= '0;
                addr_reg       <= '0;
                free_found_reg <= 1'b0;
                free_slot_reg  <= '0;
            end
            else if (ctl.advance)
            begin
                // restart the table pass for the new candidate
                addr_reg <= '0;
                if (!at_bound)
                begin
                    next_id_reg <= next_inc;
                    steps_reg   <= steps_reg + STEP_BITS'(1);
                end
            end
            else if (ctl.issue)
            begin
                addr_reg       <= addr_last ? '0 : addr_reg + SLOT_BITS'(1);
                pipe_slotv_reg <= valid_reg[addr_reg];
                pipe_last_reg  <= addr_last;
                // slots come in ascending order, so the first free one from slot 1 up is the lowest
                if (!free_found_reg && !valid_reg[addr_reg] && addr_reg != '0)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= addr_reg;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_reg.slot_found <= free_found_reg;
            out_reg.free_slot  <= SLOT_W'(free_slot_reg);
            out_reg.chosen_id  <= ID_W'(next_id_reg);
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_reg;

endmodule

// ----- rtl/process_slot_and_id_allocator_unit.sv -----
// Process slot and id allocator. Holds 64 task slots (valid mark plus 15-bit owner id)
// and a running next-id counter. Write and clear requests update one slot and return
// the current counter, as a no-op request does without updating a slot. An
// allocate walks the owner table through its single read port, one slot per cycle
// while no valid slot holds the candidate id, and ends with the first candidate that
// a full pass finds in no valid slot. Each held candidate restarts the walk and steps
// the counter (wrapping from the top id to 1, stopping on return to the starting id
// or after 65 steps). The lowest free slot from 1 upward is found during the same
// walk. One request is in flight at a time; a finished result waits in the output
// register while the next request is taken.
module process_slot_and_id_allocator_unit
    import psida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  psida_req_t req_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output psida_rsp_t rsp_data
);

    psida_ctl_t ctl;
    psida_sts_t sts;

    psida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    psida_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ----- rtl/psida_chk.sv -----
module psida_chk
    import psida_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input psida_req_t req_data,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input psida_rsp_t rsp_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

    // found flag and slot index agree
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.slot_found == (rsp_data.free_slot != '0)))
    else $error("slot_found and free_slot disagree");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

    // a request taken while no result is shown gives no result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
    else $error("result appeared without processing time");

endmodule

bind process_slot_and_id_allocator_unit psida_chk u_psida_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
